>>> src/wlt_pkg.sv
`default_nettype none
package wlt_pkg;

  // table geometry
  localparam int SLOTS    = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int RANK_W   = $clog2(SLOTS + 1);
  localparam int CURSOR_W = 16;
  localparam int CURSOR_H = 16;

  // signed 32-bit saturation bounds for translated coordinates
  localparam logic signed [31:0] SAT_HI = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_LO = 32'sh8000_0000;

  // configuration register indexes
  localparam logic [3:0] CFG_SCREEN_W = 4'd0;
  localparam logic [3:0] CFG_SCREEN_H = 4'd1;
  localparam logic [15:0] SCREEN_W_RST = 16'd640;
  localparam logic [15:0] SCREEN_H_RST = 16'd480;

  typedef enum logic [3:0] {
    OP_INIT      = 4'd0,
    OP_CREATE    = 4'd1,
    OP_DESTROY   = 4'd2,
    OP_MOVE      = 4'd3,
    OP_VISIBLE   = 4'd4,
    OP_RAISE     = 4'd5,
    OP_INVAL_WIN = 4'd6,
    OP_INVAL_DSK = 4'd7,
    OP_POINTER   = 4'd8,
    OP_CLEAR     = 4'd9
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_NO_SPACE   = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  // where a damage request takes its rectangle from
  typedef enum logic [2:0] {
    SRC_SLOT,
    SRC_NEW,
    SRC_IN,
    SRC_SCREEN,
    SRC_PTR,
    SRC_PTR_IN,
    SRC_INV
  } dmg_src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_CLIP_A,
    S_MERGE_A,
    S_POST,
    S_INV1,
    S_INV2,
    S_CLIP_B,
    S_MERGE_B,
    S_FOCUS,
    S_DONE
  } ctl_state_t;

  typedef struct packed {
    logic     latch;
    logic     scan_step;
    logic     focus_step;
    logic     init_clear;
    logic     create;
    logic     destroy;
    logic     move;
    logic     visible;
    logic     raise;
    logic     clear_dirty;
    logic     cursor;
    logic     rq_load;
    dmg_src_t rq_src;
    logic     clip;
    logic     merge;
    logic     inv1;
    logic     status_set;
    status_t  status_val;
    logic     out_load;
  } wlt_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    lookup_ok;
    logic    size_ok;
    logic    scr_ok;
    logic    shown;
    logic    vis_change;
    logic    show;
    logic    rank_is_top;
    logic    free_found;
    logic    cursor_shown;
    logic    inv_ok;
    logic    walk_last;
  } wlt_stat_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [3:0]         handle_slot;
    logic [15:0]        handle_generation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [16:0] size_w;
    logic signed [16:0] size_h;
    logic               show;
  } wlt_in_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  new_slot;
    logic [15:0] new_generation;
    logic        dirty_set;
    logic [15:0] dirty_x;
    logic [15:0] dirty_y;
    logic [15:0] dirty_w;
    logic [15:0] dirty_h;
    logic        focus_valid;
    logic [3:0]  focus_slot;
  } wlt_out_t;

endpackage
`default_nettype wire

>>> src/wlt_in_if.sv
`default_nettype none
interface wlt_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic [3:0]         handle_slot;
  logic [15:0]        handle_generation;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [16:0] size_w;
  logic signed [16:0] size_h;
  logic               show;

  modport source (output valid, opcode, handle_slot, handle_generation, pos_x, pos_y,
                  size_w, size_h, show, input ready);
  modport sink (input valid, opcode, handle_slot, handle_generation, pos_x, pos_y,
                size_w, size_h, show, output ready);
endinterface
`default_nettype wire

>>> src/wlt_out_if.sv
`default_nettype none
interface wlt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  new_slot;
  logic [15:0] new_generation;
  logic        dirty_set;
  logic [15:0] dirty_x;
  logic [15:0] dirty_y;
  logic [15:0] dirty_w;
  logic [15:0] dirty_h;
  logic        focus_valid;
  logic [3:0]  focus_slot;

  modport source (output valid, status, new_slot, new_generation, dirty_set, dirty_x,
                  dirty_y, dirty_w, dirty_h, focus_valid, focus_slot, input ready);
  modport sink (input valid, status, new_slot, new_generation, dirty_set, dirty_x,
                dirty_y, dirty_w, dirty_h, focus_valid, focus_slot, output ready);
endinterface
`default_nettype wire

>>> src/wlt_cfg_if.sv
`default_nettype none
interface wlt_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/wlt_ctrl.sv
`default_nettype none
module wlt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  wlt_pkg::wlt_stat_t stat,
  output wlt_pkg::wlt_cmd_t  cmd
);

  wlt_pkg::ctl_state_t state, state_next;
  logic handle_op;

  // state and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wlt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign handle_op = (stat.op == wlt_pkg::OP_DESTROY) || (stat.op == wlt_pkg::OP_MOVE) ||
                     (stat.op == wlt_pkg::OP_VISIBLE) || (stat.op == wlt_pkg::OP_RAISE) ||
                     (stat.op == wlt_pkg::OP_INVAL_WIN);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == wlt_pkg::S_IDLE);
    case (state)
      wlt_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = wlt_pkg::S_SCAN;
        end
      end
      wlt_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.walk_last) state_next = wlt_pkg::S_EXEC;
      end
      wlt_pkg::S_EXEC: begin
        state_next = wlt_pkg::S_FOCUS;
        if (handle_op && !stat.lookup_ok) begin
          cmd.status_set = 1'b1;
          cmd.status_val = wlt_pkg::ST_BAD_HANDLE;
        end else begin
          case (stat.op)
            wlt_pkg::OP_INIT: begin
              if (!stat.scr_ok) begin
                cmd.status_set = 1'b1;
                cmd.status_val = wlt_pkg::ST_INVALID;
              end else begin
                cmd.init_clear = 1'b1;
                cmd.rq_load    = 1'b1;
                cmd.rq_src     = wlt_pkg::SRC_SCREEN;
                state_next     = wlt_pkg::S_CLIP_B;
              end
            end
            wlt_pkg::OP_CREATE: begin
              if (!stat.size_ok) begin
                cmd.status_set = 1'b1;
                cmd.status_val = wlt_pkg::ST_INVALID;
              end else if (!stat.free_found) begin
                cmd.status_set = 1'b1;
                cmd.status_val = wlt_pkg::ST_NO_SPACE;
              end else begin
                cmd.create  = 1'b1;
                cmd.rq_load = 1'b1;
                cmd.rq_src  = wlt_pkg::SRC_IN;
                state_next  = wlt_pkg::S_CLIP_B;
              end
            end
            wlt_pkg::OP_DESTROY, wlt_pkg::OP_MOVE: begin
              if (stat.shown) begin
                cmd.rq_load = 1'b1;
                cmd.rq_src  = wlt_pkg::SRC_SLOT;
                state_next  = wlt_pkg::S_CLIP_A;
              end else begin
                state_next = wlt_pkg::S_POST;
              end
            end
            wlt_pkg::OP_VISIBLE: begin
              if (stat.vis_change) begin
                cmd.visible = 1'b1;
                cmd.rq_load = 1'b1;
                cmd.rq_src  = wlt_pkg::SRC_SLOT;
                state_next  = wlt_pkg::S_CLIP_B;
              end
            end
            wlt_pkg::OP_RAISE: begin
              if (!stat.rank_is_top) begin
                cmd.raise   = 1'b1;
                cmd.rq_load = 1'b1;
                cmd.rq_src  = wlt_pkg::SRC_SLOT;
                state_next  = wlt_pkg::S_CLIP_B;
              end
            end
            wlt_pkg::OP_INVAL_WIN: begin
              if (!stat.size_ok) begin
                cmd.status_set = 1'b1;
                cmd.status_val = wlt_pkg::ST_INVALID;
              end else begin
                cmd.inv1   = 1'b1;
                state_next = wlt_pkg::S_INV1;
              end
            end
            wlt_pkg::OP_INVAL_DSK: begin
              cmd.rq_load = 1'b1;
              cmd.rq_src  = wlt_pkg::SRC_IN;
              state_next  = wlt_pkg::S_CLIP_B;
            end
            wlt_pkg::OP_POINTER: begin
              if (stat.cursor_shown) begin
                cmd.rq_load = 1'b1;
                cmd.rq_src  = wlt_pkg::SRC_PTR;
                state_next  = wlt_pkg::S_CLIP_A;
              end else begin
                state_next = wlt_pkg::S_POST;
              end
            end
            wlt_pkg::OP_CLEAR: cmd.clear_dirty = 1'b1;
            default: begin
              cmd.status_set = 1'b1;
              cmd.status_val = wlt_pkg::ST_INVALID;
            end
          endcase
        end
      end
      wlt_pkg::S_CLIP_A: begin
        cmd.clip   = 1'b1;
        state_next = wlt_pkg::S_MERGE_A;
      end
      wlt_pkg::S_MERGE_A: begin
        cmd.merge  = 1'b1;
        state_next = wlt_pkg::S_POST;
      end
      wlt_pkg::S_POST: begin
        state_next = wlt_pkg::S_FOCUS;
        case (stat.op)
          wlt_pkg::OP_DESTROY: cmd.destroy = 1'b1;
          wlt_pkg::OP_MOVE: begin
            cmd.move = 1'b1;
            if (stat.shown) begin
              cmd.rq_load = 1'b1;
              cmd.rq_src  = wlt_pkg::SRC_NEW;
              state_next  = wlt_pkg::S_CLIP_B;
            end
          end
          wlt_pkg::OP_POINTER: begin
            cmd.cursor = 1'b1;
            if (stat.show) begin
              cmd.rq_load = 1'b1;
              cmd.rq_src  = wlt_pkg::SRC_PTR_IN;
              state_next  = wlt_pkg::S_CLIP_B;
            end
          end
          default: state_next = wlt_pkg::S_FOCUS;
        endcase
      end
      wlt_pkg::S_INV1: state_next = wlt_pkg::S_INV2;
      wlt_pkg::S_INV2: begin
        state_next = wlt_pkg::S_FOCUS;
        if (stat.inv_ok && stat.shown) begin
          cmd.rq_load = 1'b1;
          cmd.rq_src  = wlt_pkg::SRC_INV;
          state_next  = wlt_pkg::S_CLIP_B;
        end
      end
      wlt_pkg::S_CLIP_B: begin
        cmd.clip   = 1'b1;
        state_next = wlt_pkg::S_MERGE_B;
      end
      wlt_pkg::S_MERGE_B: begin
        cmd.merge  = 1'b1;
        state_next = wlt_pkg::S_FOCUS;
      end
      wlt_pkg::S_FOCUS: begin
        cmd.focus_step = 1'b1;
        if (stat.walk_last) state_next = wlt_pkg::S_DONE;
      end
      wlt_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = wlt_pkg::S_IDLE;
        end
      end
      default: state_next = wlt_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // a merge always follows the clip of the same request
  a_merge_after_clip: assert property (@(posedge clk) disable iff (rst)
    cmd.merge |-> $past(cmd.clip)) else $error("merge without clip");
  // a result appears only from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == wlt_pkg::S_DONE) else $error("stray result");
  // an accepted beat starts the slot scan
  a_accept_scans: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> state == wlt_pkg::S_SCAN) else $error("accept without scan");
  // slot writes never coincide with the output load
  a_no_write_on_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(cmd.create || cmd.destroy || cmd.move || cmd.raise))
    else $error("slot write during output load");
`endif

endmodule
`default_nettype wire

>>> src/wlt_dp.sv
`default_nettype none
module wlt_dp (
  input  logic               clk,
  input  logic               rst,
  input  wlt_pkg::wlt_cmd_t  cmd,
  output wlt_pkg::wlt_stat_t stat,
  input  wlt_pkg::wlt_in_t   in_item,
  output wlt_pkg::wlt_out_t  out_item,
  input  logic               cfg_valid,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int SW = wlt_pkg::SLOT_W;
  localparam int RW = wlt_pkg::RANK_W;

  // screen size registers
  logic [15:0] scr_w, scr_h;

  // latched command
  wlt_pkg::wlt_in_t it;

  // slot table
  logic          used  [wlt_pkg::SLOTS];
  logic          shown [wlt_pkg::SLOTS];
  logic [15:0]   gen   [wlt_pkg::SLOTS];
  logic [RW-1:0] rank  [wlt_pkg::SLOTS];
  logic signed [31:0] left_pos [wlt_pkg::SLOTS];
  logic signed [31:0] top_pos  [wlt_pkg::SLOTS];
  logic [15:0]   wid [wlt_pkg::SLOTS];
  logic [15:0]   hgt [wlt_pkg::SLOTS];

  // walk state
  logic [SW-1:0] walk;
  logic          walk_last;
  logic [RW-1:0] top_rank;
  logic          free_found;
  logic [SW-1:0] free_idx;
  logic          best_ok;
  logic [SW-1:0] best_idx;
  logic [RW-1:0] best_rank;

  // dirty box, pointer, result fields
  logic [15:0] bx_l, bx_t, bx_r, bx_b;
  logic        dmg_flag;
  logic signed [31:0] cur_x, cur_y;
  logic        cur_shown;
  wlt_pkg::status_t status;
  logic [3:0]  nslot;
  logic [15:0] ngen;

  // damage request and clip stage
  logic signed [31:0] rq_x, rq_y;
  logic signed [16:0] rq_w, rq_h;
  logic signed [31:0] rq_x_next, rq_y_next;
  logic signed [16:0] rq_w_next, rq_h_next;
  logic        cl_ok;
  logic [15:0] cl_l, cl_t, cl_r, cl_b;

  // window-invalidate stage
  logic        iv_ok;
  logic [15:0] iv_x, iv_y, iv_r, iv_b;

  logic [SW-1:0] tgt;
  logic          in_range;
  logic [15:0]   gen_inc;

  // target slot: the free slot for create, else the handle slot
  assign tgt      = (it.opcode == wlt_pkg::OP_CREATE) ? free_idx : SW'(it.handle_slot);
  assign in_range = (32'(it.handle_slot) < wlt_pkg::SLOTS);
  assign walk_last = (walk == SW'(wlt_pkg::SLOTS - 1));
  assign gen_inc  = gen[tgt] + 16'd1;

  // status toward the controller
  always_comb begin
    stat.op           = wlt_pkg::opcode_t'(it.opcode);
    stat.lookup_ok    = in_range && (it.handle_generation != 16'd0) && used[tgt] &&
                        (gen[tgt] == it.handle_generation);
    stat.size_ok      = (it.size_w > 17'sd0) && (it.size_h > 17'sd0);
    stat.scr_ok       = (scr_w != 16'd0) && (scr_h != 16'd0);
    stat.shown        = shown[tgt];
    stat.vis_change   = shown[tgt] != it.show;
    stat.show         = it.show;
    stat.rank_is_top  = rank[tgt] == top_rank;
    stat.free_found   = free_found;
    stat.cursor_shown = cur_shown;
    stat.inv_ok       = iv_ok;
    stat.walk_last    = walk_last;
  end

  // damage request source select
  logic signed [32:0] tx_sum, ty_sum;
  logic signed [31:0] tx_sat, ty_sat;
  always_comb begin
    tx_sum = $signed({17'd0, iv_x}) + 33'(left_pos[tgt]);
    ty_sum = $signed({17'd0, iv_y}) + 33'(top_pos[tgt]);
    if (tx_sum[32] != tx_sum[31]) tx_sat = tx_sum[32] ? wlt_pkg::SAT_LO : wlt_pkg::SAT_HI;
    else tx_sat = tx_sum[31:0];
    if (ty_sum[32] != ty_sum[31]) ty_sat = ty_sum[32] ? wlt_pkg::SAT_LO : wlt_pkg::SAT_HI;
    else ty_sat = ty_sum[31:0];
    case (cmd.rq_src)
      wlt_pkg::SRC_SLOT: begin
        rq_x_next = left_pos[tgt];
        rq_y_next = top_pos[tgt];
        rq_w_next = $signed({1'b0, wid[tgt]});
        rq_h_next = $signed({1'b0, hgt[tgt]});
      end
      wlt_pkg::SRC_NEW: begin
        rq_x_next = it.pos_x;
        rq_y_next = it.pos_y;
        rq_w_next = $signed({1'b0, wid[tgt]});
        rq_h_next = $signed({1'b0, hgt[tgt]});
      end
      wlt_pkg::SRC_IN: begin
        rq_x_next = it.pos_x;
        rq_y_next = it.pos_y;
        rq_w_next = it.size_w;
        rq_h_next = it.size_h;
      end
      wlt_pkg::SRC_SCREEN: begin
        rq_x_next = '0;
        rq_y_next = '0;
        rq_w_next = $signed({1'b0, scr_w});
        rq_h_next = $signed({1'b0, scr_h});
      end
      wlt_pkg::SRC_PTR: begin
        rq_x_next = cur_x;
        rq_y_next = cur_y;
        rq_w_next = 17'(wlt_pkg::CURSOR_W);
        rq_h_next = 17'(wlt_pkg::CURSOR_H);
      end
      wlt_pkg::SRC_PTR_IN: begin
        rq_x_next = it.pos_x;
        rq_y_next = it.pos_y;
        rq_w_next = 17'(wlt_pkg::CURSOR_W);
        rq_h_next = 17'(wlt_pkg::CURSOR_H);
      end
      wlt_pkg::SRC_INV: begin
        rq_x_next = tx_sat;
        rq_y_next = ty_sat;
        rq_w_next = $signed({1'b0, iv_r}) - $signed({1'b0, iv_x});
        rq_h_next = $signed({1'b0, iv_b}) - $signed({1'b0, iv_y});
      end
      default: begin
        rq_x_next = '0;
        rq_y_next = '0;
        rq_w_next = '0;
        rq_h_next = '0;
      end
    endcase
  end

  // clip a request to the screen
  logic signed [33:0] cr, cb, cl, ct, crc, cbc;
  logic               clip_ok;
  always_comb begin
    cr  = 34'(rq_x) + 34'(rq_w);
    cb  = 34'(rq_y) + 34'(rq_h);
    cl  = (rq_x < 0) ? 34'sd0 : 34'(rq_x);
    ct  = (rq_y < 0) ? 34'sd0 : 34'(rq_y);
    crc = (cr > $signed({18'd0, scr_w})) ? $signed({18'd0, scr_w}) : cr;
    cbc = (cb > $signed({18'd0, scr_h})) ? $signed({18'd0, scr_h}) : cb;
    clip_ok = (rq_w > 17'sd0) && (rq_h > 17'sd0) && (cl < crc) && (ct < cbc);
  end

  // clip a window-relative area to its surface
  logic signed [33:0] vr, vb, vrc, vbc, vx, vy;
  always_comb begin
    vr  = 34'(it.pos_x) + 34'(it.size_w);
    vb  = 34'(it.pos_y) + 34'(it.size_h);
    vx  = (it.pos_x < 0) ? 34'sd0 : 34'(it.pos_x);
    vy  = (it.pos_y < 0) ? 34'sd0 : 34'(it.pos_y);
    vrc = (vr > $signed({18'd0, wid[tgt]})) ? $signed({18'd0, wid[tgt]}) : vr;
    vbc = (vb > $signed({18'd0, hgt[tgt]})) ? $signed({18'd0, hgt[tgt]}) : vb;
  end

  // payload registers of the datapath
  always_ff @(posedge clk) begin
    if (cmd.latch) it <= in_item;
    if (cmd.rq_load) begin
      rq_x <= rq_x_next;
      rq_y <= rq_y_next;
      rq_w <= rq_w_next;
      rq_h <= rq_h_next;
    end
    if (cmd.clip) begin
      cl_ok <= clip_ok;
      cl_l  <= cl[15:0];
      cl_t  <= ct[15:0];
      cl_r  <= crc[15:0];
      cl_b  <= cbc[15:0];
    end
    if (cmd.inv1) begin
      iv_ok <= (vx < vrc) && (vy < vbc);
      iv_x  <= vx[15:0];
      iv_y  <= vy[15:0];
      iv_r  <= vrc[15:0];
      iv_b  <= vbc[15:0];
    end
    if (cmd.create) begin
      left_pos[tgt] <= it.pos_x;
      top_pos[tgt]  <= it.pos_y;
      wid[tgt]      <= it.size_w[15:0];
      hgt[tgt]      <= it.size_h[15:0];
    end
    if (cmd.move) begin
      left_pos[tgt] <= it.pos_x;
      top_pos[tgt]  <= it.pos_y;
    end
    if (cmd.out_load) begin
      out_item.status         <= status;
      out_item.new_slot       <= nslot;
      out_item.new_generation <= ngen;
      out_item.dirty_set      <= dmg_flag;
      out_item.dirty_x        <= bx_l;
      out_item.dirty_y        <= bx_t;
      out_item.dirty_w        <= bx_r - bx_l;
      out_item.dirty_h        <= bx_b - bx_t;
      out_item.focus_valid    <= best_ok;
      out_item.focus_slot     <= 4'(best_idx);
    end
  end

  // control state of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w     <= wlt_pkg::SCREEN_W_RST;
      scr_h     <= wlt_pkg::SCREEN_H_RST;
      walk      <= '0;
      top_rank  <= '0;
      free_found <= 1'b0;
      free_idx  <= '0;
      best_ok   <= 1'b0;
      best_idx  <= '0;
      best_rank <= '0;
      bx_l      <= '0;
      bx_t      <= '0;
      bx_r      <= '0;
      bx_b      <= '0;
      dmg_flag  <= 1'b0;
      cur_x     <= '0;
      cur_y     <= '0;
      cur_shown <= 1'b0;
      status    <= wlt_pkg::ST_OK;
      nslot     <= '0;
      ngen      <= '0;
      for (int i = 0; i < wlt_pkg::SLOTS; i++) begin
        used[i]  <= 1'b0;
        shown[i] <= 1'b0;
        gen[i]   <= '0;
        rank[i]  <= '0;
      end
    end else begin
      // configuration beats
      if (cfg_valid && cfg_index == wlt_pkg::CFG_SCREEN_W) scr_w <= cfg_data;
      if (cfg_valid && cfg_index == wlt_pkg::CFG_SCREEN_H) scr_h <= cfg_data;

      if (cmd.latch) begin
        top_rank   <= '0;
        free_found <= 1'b0;
        free_idx   <= '0;
        best_ok    <= 1'b0;
        best_idx   <= '0;
        best_rank  <= '0;
        status     <= wlt_pkg::ST_OK;
        nslot      <= '0;
        ngen       <= '0;
      end
      if (cmd.status_set) status <= cmd.status_val;

      // slot walk shared by the pre-scan and the focus search
      if (cmd.scan_step || cmd.focus_step) walk <= walk_last ? '0 : walk + SW'(1);
      if (cmd.scan_step) begin
        if (used[walk] && rank[walk] > top_rank) top_rank <= rank[walk];
        if (!used[walk] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= walk;
        end
      end
      if (cmd.focus_step && used[walk] && shown[walk] &&
          (!best_ok || rank[walk] > best_rank)) begin
        best_ok   <= 1'b1;
        best_idx  <= walk;
        best_rank <= rank[walk];
      end

      // slot table updates
      if (cmd.init_clear) begin
        for (int i = 0; i < wlt_pkg::SLOTS; i++) begin
          used[i]  <= 1'b0;
          shown[i] <= 1'b0;
          gen[i]   <= '0;
          rank[i]  <= '0;
        end
        cur_x     <= '0;
        cur_y     <= '0;
        cur_shown <= 1'b0;
      end
      if (cmd.create) begin
        gen[tgt]   <= (gen_inc == 16'd0) ? 16'd1 : gen_inc;
        rank[tgt]  <= top_rank + RW'(1);
        used[tgt]  <= 1'b1;
        shown[tgt] <= 1'b1;
        nslot      <= 4'(tgt);
        ngen       <= (gen_inc == 16'd0) ? 16'd1 : gen_inc;
      end
      if (cmd.destroy) begin
        for (int i = 0; i < wlt_pkg::SLOTS; i++)
          if (used[i] && rank[i] > rank[tgt]) rank[i] <= rank[i] - RW'(1);
        used[tgt]  <= 1'b0;
        shown[tgt] <= 1'b0;
      end
      if (cmd.raise) begin
        for (int i = 0; i < wlt_pkg::SLOTS; i++)
          if (used[i] && rank[i] > rank[tgt]) rank[i] <= rank[i] - RW'(1);
        rank[tgt] <= top_rank;
      end
      if (cmd.visible) shown[tgt] <= it.show;
      if (cmd.cursor) begin
        cur_x     <= it.pos_x;
        cur_y     <= it.pos_y;
        cur_shown <= it.show;
      end

      // dirty box
      if (cmd.init_clear || cmd.clear_dirty) begin
        dmg_flag <= 1'b0;
        bx_l     <= '0;
        bx_t     <= '0;
        bx_r     <= '0;
        bx_b     <= '0;
      end
      if (cmd.merge && cl_ok) begin
        dmg_flag <= 1'b1;
        if (dmg_flag) begin
          bx_l <= (bx_l < cl_l) ? bx_l : cl_l;
          bx_t <= (bx_t < cl_t) ? bx_t : cl_t;
          bx_r <= (bx_r > cl_r) ? bx_r : cl_r;
          bx_b <= (bx_b > cl_b) ? bx_b : cl_b;
        end else begin
          bx_l <= cl_l;
          bx_t <= cl_t;
          bx_r <= cl_r;
          bx_b <= cl_b;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/window_layer_table_with_dirty_union.sv
`default_nettype none
// Channel   Dir  Beat contents
// cmd_in    in   opcode, handle_slot, handle_generation, pos_x, pos_y, size_w, size_h, show
// res_out   out  status, new_slot, new_generation, dirty box, focus
// cfg       in   index (0 screen_width, 1 screen_height), data; always ready
//
// One command at a time: a slot scan over all 16 slots (top rank, first free slot), then
// update and damage clip/merge, a focus search over the slot table, then the result load.
// A result waits in the output register while the next command is taken.
// rst is synchronous: empty table, screen 640x480, no dirty box, pointer hidden.
module window_layer_table_with_dirty_union (
  input  logic       clk,
  input  logic       rst,
  wlt_in_if.sink     cmd_in,
  wlt_out_if.source  res_out,
  wlt_cfg_if.sink    cfg
);

  wlt_pkg::wlt_cmd_t  cmd;
  wlt_pkg::wlt_stat_t stat;
  wlt_pkg::wlt_in_t   in_item;
  wlt_pkg::wlt_out_t  out_item;

  assign cfg.ready = 1'b1;

  // pack the input beat
  always_comb begin
    in_item.opcode            = cmd_in.opcode;
    in_item.handle_slot       = cmd_in.handle_slot;
    in_item.handle_generation = cmd_in.handle_generation;
    in_item.pos_x             = cmd_in.pos_x;
    in_item.pos_y             = cmd_in.pos_y;
    in_item.size_w            = cmd_in.size_w;
    in_item.size_h            = cmd_in.size_h;
    in_item.show              = cmd_in.show;
  end

  // unpack the result beat
  assign res_out.status         = out_item.status;
  assign res_out.new_slot       = out_item.new_slot;
  assign res_out.new_generation = out_item.new_generation;
  assign res_out.dirty_set      = out_item.dirty_set;
  assign res_out.dirty_x        = out_item.dirty_x;
  assign res_out.dirty_y        = out_item.dirty_y;
  assign res_out.dirty_w        = out_item.dirty_w;
  assign res_out.dirty_h        = out_item.dirty_h;
  assign res_out.focus_valid    = out_item.focus_valid;
  assign res_out.focus_slot     = out_item.focus_slot;

  wlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_in.valid),
    .in_ready  (cmd_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wlt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data)
  );

endmodule
`default_nettype wire
